@@ hdl/utf8sd_pkg.sv @@
package utf8sd_pkg;

  localparam int unsigned CpWidth = 21;

  localparam logic [7:0] ContMask  = 8'hc0;
  localparam logic [7:0] ContCode  = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'he0;
  localparam logic [7:0] Lead2Code = 8'hc0;
  localparam logic [7:0] Lead3Mask = 8'hf0;
  localparam logic [7:0] Lead3Code = 8'he0;
  localparam logic [7:0] Lead4Mask = 8'hf8;
  localparam logic [7:0] Lead4Code = 8'hf0;
  localparam logic [7:0] AsciiMax  = 8'h7f;
  localparam logic [7:0] PayloadMask = 8'h3f;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               from_last_byte;
  } res_t;

endpackage

@@ hdl/utf8sd_in_if.sv @@
interface utf8sd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

@@ hdl/utf8sd_out_if.sv @@
interface utf8sd_out_if;
  logic                            valid;
  logic                            ready;
  logic [utf8sd_pkg::CpWidth-1:0]  code_point;
  logic                            from_last_byte;

  modport source (output valid, output code_point, output from_last_byte, input ready);
  modport sink (input valid, input code_point, input from_last_byte, output ready);
endinterface

@@ hdl/utf8sd_decode.sv @@
module utf8sd_decode (
  input  logic                clk,
  input  logic                rst_n,
  utf8sd_in_if.sink           in_ch,
  input  logic                res_ready,
  output logic                res_valid,
  output utf8sd_pkg::res_t    res
);

  logic [utf8sd_pkg::CpWidth-1:0] partial_r, partial_nxt;
  logic [1:0]                     expect_r, expect_nxt;
  logic [utf8sd_pkg::CpWidth-1:0] shifted;
  logic [1:0]                     expect_dec;
  logic                           acc;
  logic                           have;
  logic [7:0]                     b;

  assign in_ch.ready = res_ready;
  assign acc = in_ch.valid && in_ch.ready;
  assign b = in_ch.in_byte;

  // continuation: shift six payload bits in, keep 21 bits
  assign shifted = {partial_r[utf8sd_pkg::CpWidth-7:0], b[5:0] & utf8sd_pkg::PayloadMask[5:0]};
  assign expect_dec = expect_r - 2'd1;

  always_comb begin
    partial_nxt = partial_r;
    expect_nxt = expect_r;
    have = 1'b0;
    res.code_point = '0;
    res.from_last_byte = in_ch.end_of_string;
    if (expect_r != 2'd0) begin
      if ((b & utf8sd_pkg::ContMask) == utf8sd_pkg::ContCode) begin
        expect_nxt = expect_dec;
        if (expect_dec == 2'd0) begin
          res.code_point = shifted;
          have = (shifted != '0);
          partial_nxt = '0;
        end else begin
          partial_nxt = shifted;
        end
      end else begin
        // broken sequence: drop it and swallow this byte
        partial_nxt = '0;
        expect_nxt = 2'd0;
      end
    end else if (b <= utf8sd_pkg::AsciiMax) begin
      res.code_point = {{(utf8sd_pkg::CpWidth-8){1'b0}}, b};
      have = (b != 8'd0);
    end else if ((b & utf8sd_pkg::Lead2Mask) == utf8sd_pkg::Lead2Code) begin
      partial_nxt = {{(utf8sd_pkg::CpWidth-5){1'b0}}, b[4:0]};
      expect_nxt = 2'd1;
    end else if ((b & utf8sd_pkg::Lead3Mask) == utf8sd_pkg::Lead3Code) begin
      partial_nxt = {{(utf8sd_pkg::CpWidth-4){1'b0}}, b[3:0]};
      expect_nxt = 2'd2;
    end else if ((b & utf8sd_pkg::Lead4Mask) == utf8sd_pkg::Lead4Code) begin
      partial_nxt = {{(utf8sd_pkg::CpWidth-3){1'b0}}, b[2:0]};
      expect_nxt = 2'd3;
    end
    // end marker closes whatever is still open
    if (in_ch.end_of_string) begin
      partial_nxt = '0;
      expect_nxt = 2'd0;
    end
  end

  assign res_valid = acc && have;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      expect_r <= 2'd0;
    end else if (acc) begin
      partial_r <= partial_nxt;
      expect_r <= expect_nxt;
    end
  end

`ifndef SYNTHESIS
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    expect_r == 2'd0 |-> partial_r == '0)
    else $error("accumulator not clear with no open sequence");

  a_eos_closes: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_ch.end_of_string |=> expect_r == 2'd0)
    else $error("sequence left open after end marker");

  a_no_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> res.code_point != '0)
    else $error("zero code point emitted");

  a_ascii_pass: assert property (@(posedge clk) disable iff (!rst_n)
    acc && expect_r == 2'd0 && b != 8'd0 && b <= utf8sd_pkg::AsciiMax
    |-> res_valid && res.code_point[7:0] == b)
    else $error("ascii byte not passed through");
`endif

endmodule

@@ hdl/utf8sd_skid.sv @@
module utf8sd_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  output logic              res_ready,
  input  utf8sd_pkg::res_t  res,
  utf8sd_out_if.source      out_ch
);

  logic             out_valid_r;
  utf8sd_pkg::res_t out_data_r;
  logic             skid_valid_r;
  utf8sd_pkg::res_t skid_data_r;

  assign res_ready = !skid_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.code_point = out_data_r.code_point;
  assign out_ch.from_last_byte = out_data_r.from_last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_ch.ready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r <= 1'b1;
        out_data_r <= skid_data_r;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
        out_data_r <= res;
      end
    end else if (res_valid && res_ready) begin
      // output stalled: park the beat in the skid slot
      skid_valid_r <= 1'b1;
      skid_data_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot full with empty output register");

  a_skid_from_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_ch.ready))
    else $error("skid filled without a stall");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && out_ch.ready |=> !skid_valid_r && out_valid_r)
    else $error("skid slot did not drain");
`endif

endmodule

@@ hdl/utf8_stream_decoder.sv @@
// utf8 stream decoder: one byte in per cycle unless stalled, one code point out
// a code point is held in the output register, or in the skid slot on a stall
// throughput: one byte per cycle while the skid slot is empty
// output register plus skid slot: input closes only while the skid slot holds a beat
// reset (synchronous, active low) clears the open sequence and both output slots
module utf8_stream_decoder (
  input  logic          clk,
  input  logic          rst_n,
  utf8sd_in_if.sink     in_ch,
  utf8sd_out_if.source  out_ch
);

  logic             res_valid;
  logic             res_ready;
  utf8sd_pkg::res_t res;

  utf8sd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  utf8sd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_ch    (out_ch)
  );

endmodule

@@ tb/sv/utf8_stream_decoder_tb.sv @@
module utf8_stream_decoder_tb;

  typedef enum logic [1:0] {
    CHK_PREDICT,
    CHK_NONE,
    CHK_VALUE
  } row_chk_t;

  typedef struct packed {
    logic [7:0]                     in_byte;
    logic                           eos;
    row_chk_t                       chk;
    logic [utf8sd_pkg::CpWidth-1:0] code_point;
    logic                           from_last_byte;
  } stim_row_t;

  localparam int NumRows = 24;
  localparam int RandomBytes = 1400;

  // directed table: typed expectations only where obvious, the rest goes through decode_byte
  localparam stim_row_t DirectedRows [NumRows] = '{
    '{8'h41, 1'b0, CHK_VALUE,   21'h000041, 1'b0},
    '{8'h00, 1'b0, CHK_NONE,    21'h0,      1'b0},  // zero byte gives nothing
    '{8'h7f, 1'b1, CHK_VALUE,   21'h00007f, 1'b1},
    '{8'h80, 1'b0, CHK_NONE,    21'h0,      1'b0},  // stray continuation
    '{8'hf8, 1'b0, CHK_NONE,    21'h0,      1'b0},  // invalid lead
    '{8'hc3, 1'b0, CHK_PREDICT, 21'h0,      1'b0},
    '{8'ha9, 1'b0, CHK_PREDICT, 21'h0,      1'b0},
    '{8'he2, 1'b0, CHK_PREDICT, 21'h0,      1'b0},
    '{8'h82, 1'b0, CHK_PREDICT, 21'h0,      1'b0},
    '{8'hac, 1'b0, CHK_PREDICT, 21'h0,      1'b0},
    '{8'hf7, 1'b0, CHK_PREDICT, 21'h0,      1'b0},
    '{8'hbf, 1'b0, CHK_PREDICT, 21'h0,      1'b0},
    '{8'hbf, 1'b0, CHK_PREDICT, 21'h0,      1'b0},
    '{8'hbf, 1'b1, CHK_VALUE,   21'h1fffff, 1'b1},
    '{8'hc3, 1'b0, CHK_PREDICT, 21'h0,      1'b0},
    '{8'h41, 1'b0, CHK_NONE,    21'h0,      1'b0},  // broken sequence eats this byte
    '{8'h42, 1'b0, CHK_VALUE,   21'h000042, 1'b0},
    '{8'hc0, 1'b0, CHK_PREDICT, 21'h0,      1'b0},
    '{8'h80, 1'b0, CHK_NONE,    21'h0,      1'b0},  // decodes to zero
    '{8'he2, 1'b0, CHK_PREDICT, 21'h0,      1'b0},
    '{8'h82, 1'b1, CHK_NONE,    21'h0,      1'b0},  // end marker cuts the sequence
    '{8'h82, 1'b0, CHK_NONE,    21'h0,      1'b0},
    '{8'hf0, 1'b1, CHK_NONE,    21'h0,      1'b0},  // lead on the marked byte
    '{8'h41, 1'b0, CHK_VALUE,   21'h000041, 1'b0}
  };

  logic clk;
  logic rst_n;

  utf8sd_in_if  in_ch ();
  utf8sd_out_if out_ch ();

  utf8_stream_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // decoder state mirror
  logic [utf8sd_pkg::CpWidth-1:0] acc_value;
  logic [1:0]                     cont_left;

  utf8sd_pkg::res_t pending_code_points [$];
  utf8sd_pkg::res_t oldest_cp;
  int   mismatch_count;
  int   bytes_sent;
  bit   idle_on;
  int   out_stall_left;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void decode_byte(input logic [7:0] b, input logic eos,
                                      output logic have, output utf8sd_pkg::res_t cp);
    logic [utf8sd_pkg::CpWidth-1:0] val;
    have = 1'b0;
    val  = '0;
    if (cont_left != 2'd0) begin
      if ((b & utf8sd_pkg::ContMask) == utf8sd_pkg::ContCode) begin
        acc_value = (acc_value << 6) | utf8sd_pkg::CpWidth'(b & utf8sd_pkg::PayloadMask);
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          val       = acc_value;
          have      = (val != '0);
          acc_value = '0;
        end
      end else begin
        acc_value = '0;
        cont_left = 2'd0;
      end
    end else if (b <= utf8sd_pkg::AsciiMax) begin
      val  = utf8sd_pkg::CpWidth'(b);
      have = (b != 8'h00);
    end else if ((b & utf8sd_pkg::Lead2Mask) == utf8sd_pkg::Lead2Code) begin
      acc_value = utf8sd_pkg::CpWidth'(b & ~utf8sd_pkg::Lead2Mask);
      cont_left = 2'd1;
    end else if ((b & utf8sd_pkg::Lead3Mask) == utf8sd_pkg::Lead3Code) begin
      acc_value = utf8sd_pkg::CpWidth'(b & ~utf8sd_pkg::Lead3Mask);
      cont_left = 2'd2;
    end else if ((b & utf8sd_pkg::Lead4Mask) == utf8sd_pkg::Lead4Code) begin
      acc_value = utf8sd_pkg::CpWidth'(b & ~utf8sd_pkg::Lead4Mask);
      cont_left = 2'd3;
    end
    if (eos) begin
      acc_value = '0;
      cont_left = 2'd0;
    end
    cp.code_point     = val;
    cp.from_last_byte = eos;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_beat(input logic [7:0] b, input logic eos, input row_chk_t chk,
                           input utf8sd_pkg::res_t typed);
    int               gap;
    logic             have;
    utf8sd_pkg::res_t cp;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.in_byte       <= b;
    in_ch.end_of_string <= eos;
    do @(posedge clk); while (!in_ch.ready);
    decode_byte(b, eos, have, cp);
    case (chk)
      CHK_PREDICT: if (have) pending_code_points.push_back(cp);
      CHK_VALUE:   pending_code_points.push_back(typed);
      default: ;
    endcase
    @(negedge clk);
  endtask

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  // mostly well-formed sequences, some broken or cut short, a little raw noise
  task automatic send_random_sequence();
    logic [7:0] seq [4];
    logic [7:0] bad;
    logic       eos;
    int         pick;
    int         n;
    int         stop;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0, CHK_PREDICT, '0);
      bytes_sent++;
      return;
    end
    n = $urandom_range(1, 4);
    case (n)
      1: seq[0] = {1'b0, 7'($urandom_range(0, 127))};
      2: seq[0] = {3'b110, 5'($urandom_range(0, 31))};
      3: seq[0] = {4'b1110, 4'($urandom_range(0, 15))};
      default: seq[0] = {5'b11110, 3'($urandom_range(0, 7))};
    endcase
    for (int i = 1; i < 4; i++) seq[i] = cont_byte();
    stop = n - 1;
    eos  = ($urandom_range(0, 7) == 0);
    if (n > 1 && pick >= 80 && pick < 90) begin
      stop = $urandom_range(1, n - 1);
      bad  = 8'($urandom_range(0, 255));
      while (bad[7:6] == 2'b10) bad = 8'($urandom_range(0, 255));
      seq[stop] = bad;
    end else if (n > 1 && pick >= 90) begin
      stop = $urandom_range(0, n - 2);
      eos  = 1'b1;
    end
    for (int i = 0; i <= stop; i++) begin
      send_beat(seq[i], (i == stop) ? eos : 1'b0, CHK_PREDICT, '0);
      bytes_sent++;
    end
  endtask

  always @(negedge clk) begin
    if (idle_on && out_stall_left == 0 && $urandom_range(0, 5) == 0)
      out_stall_left = $urandom_range(1, 6);
    if (out_stall_left != 0) begin
      out_ch.ready <= 1'b0;
      out_stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_code_points.size() == 0) begin
        report_mismatch($sformatf("unexpected code point %h", out_ch.code_point));
      end else begin
        oldest_cp = pending_code_points.pop_front();
        if (out_ch.code_point !== oldest_cp.code_point)
          report_mismatch($sformatf("code_point %h, want %h",
                                    out_ch.code_point, oldest_cp.code_point));
        if (out_ch.from_last_byte !== oldest_cp.from_last_byte)
          report_mismatch($sformatf("from_last_byte %b, want %b (code point %h)",
                                    out_ch.from_last_byte, oldest_cp.from_last_byte,
                                    oldest_cp.code_point));
      end
    end
  end

  initial begin
    int next_switch;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.in_byte       = 8'h00;
    in_ch.end_of_string = 1'b0;
    out_ch.ready        = 1'b0;
    acc_value           = '0;
    cont_left           = 2'd0;
    mismatch_count      = 0;
    bytes_sent          = 0;
    out_stall_left      = 0;
    idle_on             = 1'b1;
    next_switch         = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NumRows; i++)
      send_beat(DirectedRows[i].in_byte, DirectedRows[i].eos, DirectedRows[i].chk,
                '{code_point: DirectedRows[i].code_point,
                  from_last_byte: DirectedRows[i].from_last_byte});

    while (bytes_sent < RandomBytes) begin
      // idling switches per stretch of beats, and stops for the tail of the run
      if (bytes_sent >= next_switch) begin
        next_switch += 100;
        idle_on = (bytes_sent < RandomBytes - 200) && ($urandom_range(0, 3) != 0);
      end
      send_random_sequence();
    end
    in_ch.valid <= 1'b0;

    while (pending_code_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending_code_points.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
